// File: rtl/pfc_pkg.sv
package pfc_pkg;

  localparam int WINDOW_MAX_DEF = 256;

  // shared serial multiplier and divider widths
  localparam int PROD_W = 85;
  localparam int MB_W   = 39;
  localparam int DIV_W  = 85;
  localparam int DEN_W  = 33;
  localparam int CNT_W  = 7;
  localparam int ACC_W  = 56;

  localparam logic [23:0] DRIVE_LIMIT_RST   = 24'd6553600;
  localparam logic [8:0]  WINDOW_LENGTH_RST = 9'd50;
  localparam logic [31:0] I_SCALE           = 32'd256000000;
  localparam logic [31:0] MICROS_PER_S      = 32'd1000000;
  localparam logic [DIV_W-1:0] D_SAT        = DIV_W'(1) << 60;
  // ceil(2^52 / 15625), exact quotient for dividends below 2^38
  localparam logic [MB_W-1:0] I_RECIP       = 39'd288230376152;

  typedef enum logic [2:0] {
    REG_TARGET      = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_FULL_SCALE  = 3'd5,
    REG_WINDOW      = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_WIN,
    S_MEAN,
    S_MULP,
    S_MULS,
    S_MULB,
    S_DIVB,
    S_MULI,
    S_DIVI,
    S_MULDE,
    S_MULD,
    S_DIVD,
    S_DIVF,
    S_SUM,
    S_OUT
  } state_t;

endpackage

// File: rtl/pid_flow_controller_moving_average.sv
// Flow controller: PID with feed-forward on a moving average of the flow.
// Input channel (in_valid/in_ready) carries flow_sample and interval_us; the
// output channel (out_valid/out_ready) returns one drive value per input.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// only while the block is idle; the user must keep to this, as the block
// itself does not enforce it. Writing window_length restarts the controller.
// A zero interval returns the held drive and changes nothing. Otherwise the
// window update reads and writes the sample memory once, then a shared
// shift-add multiplier and a shared restoring divider, one bit per cycle
// each, form the mean, the PID terms, the anti-windup bound and the
// feed-forward in turn. One item is worked at a time; in_ready is high
// whenever no item is at work, also while a finished drive still waits in
// the output register. When the receiver stalls, the next result waits
// until the output register is free. Reset clears the controller state and
// loads register defaults; the sample memory needs no clearing, since only
// entries written since the last restart are read.
module pid_flow_controller_moving_average
  import pfc_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] flow_sample,
  input  logic [19:0]        interval_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        drive,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = 32 + $clog2(WINDOW_MAX);

  // configuration
  logic [30:0] target_flow;
  logic [31:0] gain_p, gain_i, gain_d;
  logic [23:0] drive_limit;
  logic [30:0] full_scale_flow;
  logic [8:0]  window_length;

  // controller state
  logic [31:0]             sample_mem [WINDOW_MAX];
  logic [31:0]             rdata;
  logic signed [SW-1:0]    window_sum;
  logic [AW-1:0]           write_pointer;
  logic [CW-1:0]           fill_count;
  logic signed [ACC_W-1:0] integral_acc;
  logic signed [32:0]      last_error;
  logic                    first_step;
  logic [23:0]             held_drive;

  state_t state, state_next;

  // item scratch
  logic [31:0]        sample;
  logic [19:0]        dt;
  logic               sum_neg;
  logic signed [32:0] err;
  logic [55:0]        p_mag;
  logic [24:0]        i_mag;
  logic [60:0]        d_mag;
  logic               de_neg;
  logic [53:0]        ff;
  logic [23:0]        result;

  // serial units
  logic [PROD_W-1:0] ma, prod;
  logic [MB_W-1:0]   mb;
  logic [DIV_W-1:0]  dq;
  logic [DEN_W-1:0]  drem, dden;
  logic [CNT_W-1:0]  dcnt;
  logic              mul_done, div_done;

  assign mul_done = (mb == '0);
  assign div_done = (dcnt == '0);

  logic [DEN_W:0]   div_t;
  logic             div_ge;
  logic [DEN_W-1:0] drem_step;

  assign div_t     = {drem, dq[DIV_W-1]};
  assign div_ge    = (div_t >= {1'b0, dden});
  assign drem_step = div_ge ? DEN_W'(div_t - {1'b0, dden}) : div_t[DEN_W-1:0];

  // window arithmetic
  logic [CW-1:0]        len_eff;
  logic                 win_full;
  logic signed [SW-1:0] sum_next;
  logic [CW-1:0]        fill_next;
  logic [AW-1:0]        wp_next;
  logic [SW-1:0]        sum_mag;

  always_comb begin
    if (window_length == '0) begin
      len_eff = CW'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      len_eff = CW'(WINDOW_MAX);
    end else begin
      len_eff = CW'(window_length);
    end
  end

  assign win_full  = (fill_count >= len_eff);
  assign fill_next = win_full ? fill_count : fill_count + CW'(1);
  assign sum_next  = window_sum
                   - (win_full ? SW'($signed(rdata)) : SW'(0))
                   + SW'($signed(sample));
  assign sum_mag   = sum_next[SW-1] ? SW'(-sum_next) : SW'(sum_next);
  assign wp_next   = ((CW'(write_pointer) + CW'(1)) >= len_eff) ? '0
                   : write_pointer + AW'(1);

  // error from the mean quotient
  logic signed [33:0] mean_s, err34;
  logic signed [32:0] err_calc;
  logic [31:0]        err_calc_mag, err_mag;

  assign mean_s       = sum_neg ? -$signed({2'b0, dq[31:0]}) : $signed({2'b0, dq[31:0]});
  assign err34        = $signed({3'b0, target_flow}) - mean_s;
  assign err_calc     = err34[32:0];
  assign err_calc_mag = err_calc[32] ? 32'(-err_calc) : err_calc[31:0];
  assign err_mag      = err[32] ? 32'(-err) : err[31:0];

  // integral with anti-windup
  logic signed [ACC_W-1:0] step_s, bound_s, acc_clamped;

  assign step_s      = err[32] ? -$signed(ACC_W'(prod[51:0])) : $signed(ACC_W'(prod[51:0]));
  assign bound_s     = $signed(ACC_W'(dq[51:0]));
  assign acc_clamped = (integral_acc > bound_s)  ? bound_s
                     : (integral_acc < -bound_s) ? -bound_s : integral_acc;

  // derivative difference
  logic signed [33:0] de;
  logic [32:0]        de_mag;

  assign de     = 34'(err) - 34'(last_error);
  assign de_mag = de[33] ? 33'(-de) : 33'(de);

  // feed-forward numerator: target * 100 * 2^16
  logic [53:0] ff_num;
  assign ff_num = (54'(target_flow) * 54'd100) << 16;

  // final sum and clamp
  logic signed [63:0] p_s, i_s, d_s, total;
  logic [23:0]        total_clamped;

  assign p_s   = err[32] ? -$signed(64'(p_mag)) : $signed(64'(p_mag));
  assign i_s   = integral_acc[ACC_W-1] ? -$signed(64'(i_mag)) : $signed(64'(i_mag));
  assign d_s   = de_neg ? -$signed(64'(d_mag)) : $signed(64'(d_mag));
  assign total = $signed(64'(ff)) + p_s + i_s + d_s;

  always_comb begin
    if (total[63]) begin
      total_clamped = '0;
    end else if (total > $signed(64'(drive_limit))) begin
      total_clamped = drive_limit;
    end else begin
      total_clamped = total[23:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = (interval_us == '0) ? S_OUT : S_READ;
      S_READ:  state_next = S_WIN;
      S_WIN:   state_next = S_MEAN;
      S_MEAN:  if (div_done) state_next = S_MULP;
      S_MULP:  if (mul_done) state_next = S_MULS;
      S_MULS:  if (mul_done) state_next = S_MULB;
      S_MULB:  if (mul_done) state_next = S_DIVB;
      S_DIVB:  if (div_done) state_next = S_MULI;
      S_MULI:  if (mul_done) state_next = S_DIVI;
      S_DIVI: begin
        if (mul_done) begin
          if (!first_step) state_next = S_MULDE;
          else state_next = (full_scale_flow != '0) ? S_DIVF : S_SUM;
        end
      end
      S_MULDE: if (mul_done) state_next = S_MULD;
      S_MULD:  if (mul_done) state_next = S_DIVD;
      S_DIVD:  if (div_done) state_next = (full_scale_flow != '0) ? S_DIVF : S_SUM;
      S_DIVF:  if (div_done) state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (state == S_WIN) begin
      sample_mem[write_pointer] <= sample;
    end
    rdata <= sample_mem[write_pointer];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      drive     <= result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_flow     <= '0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      drive_limit     <= DRIVE_LIMIT_RST;
      full_scale_flow <= '0;
      window_length   <= WINDOW_LENGTH_RST;
      window_sum      <= '0;
      write_pointer   <= '0;
      fill_count      <= '0;
      integral_acc    <= '0;
      last_error      <= '0;
      first_step      <= 1'b1;
      held_drive      <= '0;
      mb              <= '0;
      dcnt            <= '0;
    end else begin
      if (mb != '0) begin
        if (mb[0]) prod <= prod + ma;
        ma <= ma << 1;
        mb <= mb >> 1;
      end
      if (dcnt != '0) begin
        drem <= drem_step;
        dq   <= {dq[DIV_W-2:0], div_ge};
        dcnt <= dcnt - CNT_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample <= flow_sample;
            dt     <= interval_us;
            result <= held_drive;
          end
        end
        S_WIN: begin
          window_sum    <= sum_next;
          fill_count    <= fill_next;
          write_pointer <= wp_next;
          sum_neg       <= sum_next[SW-1];
          dq            <= DIV_W'(sum_mag) << (DIV_W - SW);
          dden          <= DEN_W'(fill_next);
          drem          <= '0;
          dcnt          <= CNT_W'(SW);
        end
        S_MEAN: begin
          if (div_done) begin
            err  <= err_calc;
            ma   <= PROD_W'(err_calc_mag);
            mb   <= MB_W'(gain_p);
            prod <= '0;
          end
        end
        S_MULP: begin
          if (mul_done) begin
            p_mag <= prod[63:8];
            ma    <= PROD_W'(err_mag);
            mb    <= MB_W'(dt);
            prod  <= '0;
          end
        end
        S_MULS: begin
          if (mul_done) begin
            integral_acc <= integral_acc + step_s;
            ma           <= PROD_W'(drive_limit);
            mb           <= MB_W'(I_SCALE);
            prod         <= '0;
          end
        end
        S_MULB: begin
          if (mul_done) begin
            dq   <= DIV_W'(prod[51:0]) << (DIV_W - 52);
            dden <= DEN_W'(gain_i) + DEN_W'(1);
            drem <= '0;
            dcnt <= CNT_W'(52);
          end
        end
        S_DIVB: begin
          if (div_done) begin
            integral_acc <= acc_clamped;
            ma           <= PROD_W'(acc_clamped[ACC_W-1] ? 53'(-acc_clamped)
                                                         : 53'(acc_clamped));
            mb           <= MB_W'(gain_i);
            prod         <= '0;
          end
        end
        S_MULI: begin
          if (mul_done) begin
            // product stays below 2^52: divide by 2^14, then by 15625 via reciprocal
            ma   <= PROD_W'(prod[51:14]);
            mb   <= I_RECIP;
            prod <= '0;
          end
        end
        S_DIVI: begin
          if (mul_done) begin
            i_mag  <= prod[76:52];
            d_mag  <= '0;
            de_neg <= de[33];
            ff     <= '0;
            if (!first_step) begin
              ma   <= PROD_W'(de_mag);
              mb   <= MB_W'(MICROS_PER_S);
              prod <= '0;
            end else if (full_scale_flow != '0) begin
              dq   <= DIV_W'(ff_num) << (DIV_W - 54);
              dden <= DEN_W'(full_scale_flow);
              drem <= '0;
              dcnt <= CNT_W'(54);
            end
          end
        end
        S_MULDE: begin
          if (mul_done) begin
            ma   <= prod;
            mb   <= MB_W'(gain_d);
            prod <= '0;
          end
        end
        S_MULD: begin
          if (mul_done) begin
            dq   <= prod;
            dden <= DEN_W'({dt, 8'b0});
            drem <= '0;
            dcnt <= CNT_W'(DIV_W);
          end
        end
        S_DIVD: begin
          if (div_done) begin
            d_mag <= (dq > D_SAT) ? D_SAT[60:0] : dq[60:0];
            if (full_scale_flow != '0) begin
              dq   <= DIV_W'(ff_num) << (DIV_W - 54);
              dden <= DEN_W'(full_scale_flow);
              drem <= '0;
              dcnt <= CNT_W'(54);
            end
          end
        end
        S_DIVF: begin
          if (div_done) ff <= dq[53:0];
        end
        S_SUM: begin
          result     <= total_clamped;
          held_drive <= total_clamped;
          last_error <= err;
          first_step <= 1'b0;
        end
        default: begin
        end
      endcase

      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET:      target_flow     <= cfg_data[30:0];
          REG_GAIN_P:      gain_p          <= cfg_data;
          REG_GAIN_I:      gain_i          <= cfg_data;
          REG_GAIN_D:      gain_d          <= cfg_data;
          REG_DRIVE_LIMIT: drive_limit     <= cfg_data[23:0];
          REG_FULL_SCALE:  full_scale_flow <= cfg_data[30:0];
          REG_WINDOW: begin
            // new window length restarts the controller
            window_length <= cfg_data[8:0];
            window_sum    <= '0;
            write_pointer <= '0;
            fill_count    <= '0;
            integral_acc  <= '0;
            last_error    <= '0;
            first_step    <= 1'b1;
            held_drive    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
